// ----- rtl/core/rau_pkg.sv -----
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package rau_pkg;
  localparam int OperandWidth = 32;
  localparam int ProdWidth = 64;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_CMP = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic        invalid;
    logic        less;
    logic        equal;
    logic        greater;
  } out_item_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;
endpackage

// ----- rtl/core/rau_divider.sv -----
// rau_divider: shared restoring divider, one quotient bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps
module rau_divider import rau_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  div_ctrl_t             ctrl,
  input  logic [ProdWidth-1:0]  dividend,
  input  logic [ProdWidth-1:0]  divisor,
  output logic                  done,
  output logic [ProdWidth-1:0]  quotient,
  output logic [ProdWidth-1:0]  remainder
);
  logic [ProdWidth-1:0] rem;
  logic [ProdWidth-1:0] quo;
  logic [ProdWidth-1:0] dvs;
  logic [6:0] count;
  logic busy;
  logic [ProdWidth:0] shifted;
  logic [ProdWidth:0] diff;

  assign shifted = {rem, quo[ProdWidth-1]};
  assign diff = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == 7'd1);
      if (ctrl.start) begin
        busy <= 1'b1;
        count <= 7'(ProdWidth);
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (busy) begin
        rem <= diff[ProdWidth] ? shifted[ProdWidth-1:0] : diff[ProdWidth-1:0];
        quo <= {quo[ProdWidth-2:0], !diff[ProdWidth]};
        count <= count - 7'd1;
        busy <= (count != 7'd1);
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem;
endmodule

// ----- rtl/core/rational_arithmetic_unit.sv -----
// rational arithmetic unit: one 64-bit divider shared by gcd and reduction
// compare and special cases go straight to the output; otherwise one euclid step
// per divider pass finds the gcd, then two passes divide it out of num and den
// throughput: one transaction at a time, next accepted after the result leaves
// in_stall high while busy or the result waits
// rst (synchronous) returns the sequencer to idle and drops out_valid
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MUL1  = 8'b00000010,
    S_MUL2  = 8'b00000100,
    S_FORM  = 8'b00001000,
    S_GCD   = 8'b00010000,
    S_QNUM  = 8'b00100000,
    S_QDEN  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  logic [2:0] func;
  logic signed [OperandWidth-1:0] an, bn;
  logic signed [OperandWidth:0] ad, bd;
  logic signed [63:0] p1, p2, p3;
  logic signed [63:0] rnum;
  logic [63:0] nmag, dmag;
  logic [63:0] nm, dm, gx, gy, qn;
  logic neg;
  logic waiting;
  logic arith;
  logic go_gcd;
  logic div_go;
  out_item_t result;
  out_item_t form_result;
  out_item_t red_result;
  div_ctrl_t dctrl;
  logic [63:0] dvd, dvs, dq, dr;
  logic ddone;

  rau_divider u_div (
    .clk(clk), .rst(rst), .ctrl(dctrl), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quotient(dq), .remainder(dr)
  );

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = result;

  assign div_go = ((state == S_GCD) && !waiting) || ((state == S_QNUM) && ddone);

  // raw fraction or compare flags from the products
  always_comb begin
    form_result = '0;
    form_result.res_den = 63'd1;
    arith = 1'b0;
    rnum = p1 - p2;
    case (func)
      FUNC_ADD: begin
        arith = 1'b1;
        rnum = p1 + p2;
      end
      FUNC_SUB: begin
        arith = 1'b1;
      end
      FUNC_MUL, FUNC_DIV: begin
        arith = 1'b1;
        rnum = p1;
      end
      FUNC_CMP: begin
        form_result.less = rnum[63];
        form_result.equal = (rnum == 0);
        form_result.greater = !rnum[63] && (rnum != 0);
      end
      default: ;
    endcase
    form_result.invalid = arith && (p3 == 0);
    go_gcd = arith && (p3 != 0) && (rnum != 0);
    nmag = rnum[63] ? -rnum : rnum;
    dmag = p3[63] ? -p3 : p3;
  end

  always_comb begin
    red_result = '0;
    red_result.res_num = neg ? -qn : qn;
    red_result.res_den = dq[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      waiting <= 1'b0;
      dctrl <= '0;
    end else begin
      dctrl.start <= div_go;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func <= in_data.func;
            an <= in_data.a_num[OperandWidth-1:0];
            bn <= in_data.b_num[OperandWidth-1:0];
            ad <= {2'b00, in_data.a_den[OperandWidth-2:0]};
            bd <= {2'b00, in_data.b_den[OperandWidth-2:0]};
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1 <= 64'(an * (func == FUNC_MUL ? 33'(bn) : bd));
          p2 <= 64'(33'(bn) * ad);
          state <= S_MUL2;
        end
        S_MUL2: begin
          p3 <= 64'(ad * (func == FUNC_DIV ? 33'(bn) : bd));
          state <= S_FORM;
        end
        S_FORM: begin
          result <= form_result;
          neg <= rnum[63] ^ p3[63];
          nm <= nmag;
          dm <= dmag;
          gx <= nmag;
          gy <= dmag;
          waiting <= 1'b0;
          state <= go_gcd ? S_GCD : S_OUT;
        end
        S_GCD: begin
          if (!waiting) begin
            if (gy == 0) begin
              dvd <= nm;
              dvs <= gx;
              waiting <= 1'b1;
              state <= S_QNUM;
            end else begin
              dvd <= gx;
              dvs <= gy;
              waiting <= 1'b1;
            end
          end else if (ddone) begin
            gx <= gy;
            gy <= dr;
            waiting <= 1'b0;
          end
        end
        S_QNUM: begin
          if (ddone) begin
            qn <= dq;
            dvd <= dm;
            dvs <= gx;
            state <= S_QDEN;
          end
        end
        S_QDEN: begin
          if (ddone) begin
            result <= red_result;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && func == FUNC_CMP |->
      $countones({result.less, result.equal, result.greater}) == 1)
    else $error("compare flags not exclusive");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.res_den != 0)
    else $error("zero result denominator");
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.invalid |-> result.res_num == 0)
    else $error("invalid result with nonzero numerator");
endmodule
